// ===== hw/rtl/srsm_pkg.sv =====
// Shared types, codes and defaults for the shared ring slot manager.
// No dependencies; used by srsm_eval and shared_ring_slot_manager.
`timescale 1ns / 1ps

package srsm_pkg;

  localparam int INDEX_BITS_DEFAULT = 16;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 64;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_SLOT_COUNT  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SLOT_BYTES  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_REGION_BASE = 2'd2;

  localparam logic [15:0] SLOT_COUNT_RESET  = 16'd16;
  localparam logic [15:0] SLOT_BYTES_RESET  = 16'd64;
  localparam logic [63:0] REGION_BASE_RESET = 64'd0;

  localparam logic ACT_ENQUEUE = 1'b0;
  localparam logic ACT_DEQUEUE = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_AGAIN = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  typedef struct packed {
    logic        action;
    logic [15:0] request_length;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] slot_address;
    logic [15:0] transfer_length;
    logic [31:0] enqueued_total;
    logic [31:0] dequeued_total;
  } rsp_t;

  typedef struct packed {
    logic [15:0] slot_count;
    logic [15:0] slot_bytes;
    logic [63:0] region_base;
  } cfg_t;

  typedef struct packed {
    logic [31:0] enqueue_counter;
    logic [31:0] dequeue_counter;
  } counters_t;

endpackage

// ===== hw/rtl/srsm_eval.sv =====
// Request evaluation: checks, ring full/empty test, index advance, slot address.
// Purely combinational; depends on srsm_pkg.
`timescale 1ns / 1ps

module srsm_eval #(
  parameter int INDEX_BITS = srsm_pkg::INDEX_BITS_DEFAULT
) (
  input  srsm_pkg::req_t        req,
  input  srsm_pkg::cfg_t        cfg,
  input  logic [INDEX_BITS-1:0] write_index,
  input  logic [INDEX_BITS-1:0] read_index,
  input  srsm_pkg::counters_t   counters,
  output logic [INDEX_BITS-1:0] write_index_next,
  output logic [INDEX_BITS-1:0] read_index_next,
  output srsm_pkg::counters_t   counters_next,
  output srsm_pkg::rsp_t        rsp
);

  function automatic logic [INDEX_BITS-1:0] advance(
    input logic [INDEX_BITS-1:0] idx,
    input logic [15:0]           count
  );
    logic [15:0] n;
    n = 16'(idx) + 16'd1;
    if (n >= count) begin
      n = n - count;
    end
    return INDEX_BITS'(n);
  endfunction

  logic [INDEX_BITS-1:0] adv_write;
  logic [INDEX_BITS-1:0] adv_read;
  logic [INDEX_BITS-1:0] addr_index;
  logic [16:0]           slot_number;
  logic [32:0]           slot_offset;
  logic [63:0]           address;
  logic [15:0]           dequeue_length;

  assign adv_write      = advance(write_index, cfg.slot_count);
  assign adv_read       = advance(read_index, cfg.slot_count);
  assign addr_index     = (req.action == srsm_pkg::ACT_DEQUEUE) ? read_index : write_index;
  assign slot_number    = 17'(addr_index) + 17'd1;
  assign slot_offset    = 33'(slot_number) * 33'(cfg.slot_bytes);
  assign address        = cfg.region_base + 64'(slot_offset);
  assign dequeue_length = (req.request_length < cfg.slot_bytes) ? req.request_length
                                                                : cfg.slot_bytes;

  always_comb begin
    write_index_next    = write_index;
    read_index_next     = read_index;
    counters_next       = counters;
    rsp.status          = srsm_pkg::ST_OK;
    rsp.slot_address    = 64'd0;
    rsp.transfer_length = 16'd0;
    priority if (req.request_length == 16'd0) begin
      rsp.status = srsm_pkg::ST_ERROR;
    end else if (req.action == srsm_pkg::ACT_ENQUEUE) begin
      priority if (req.request_length > cfg.slot_bytes) begin
        rsp.status = srsm_pkg::ST_ERROR;
      end else if (adv_write == read_index) begin
        rsp.status = srsm_pkg::ST_AGAIN;
      end else begin
        rsp.slot_address              = address;
        rsp.transfer_length           = req.request_length;
        write_index_next              = adv_write;
        counters_next.enqueue_counter = counters.enqueue_counter + 32'd1;
      end
    end else begin
      priority if (read_index == write_index) begin
        rsp.status = srsm_pkg::ST_AGAIN;
      end else begin
        rsp.slot_address              = address;
        rsp.transfer_length           = dequeue_length;
        read_index_next               = adv_read;
        counters_next.dequeue_counter = counters.dequeue_counter + 32'd1;
      end
    end
    rsp.enqueued_total = counters_next.enqueue_counter;
    rsp.dequeued_total = counters_next.dequeue_counter;
  end

endmodule

// ===== hw/rtl/shared_ring_slot_manager.sv =====
// Shared ring slot manager: request register, evaluation, result register.
// A request beat is captured in the request register, then evaluated and its result captured in the result register.
// Throughput: one request per cycle while rsp_ready does not stall the result register, set by the index update and
// the 17x16 multiply-add for the slot address between the two registers.
// Reset (rst, synchronous): indices and counters cleared, registers at 16/64/0.
// Depends on srsm_pkg and srsm_eval.
`timescale 1ns / 1ps

module shared_ring_slot_manager #(
  parameter int INDEX_BITS = srsm_pkg::INDEX_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_ready,
  input  srsm_pkg::req_t                      req,
  output logic                                rsp_valid,
  input  logic                                rsp_ready,
  output srsm_pkg::rsp_t                      rsp,
  input  logic                                cfg_we,
  input  logic [srsm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [srsm_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);

  srsm_pkg::cfg_t        cfg;
  srsm_pkg::req_t        held_req;
  logic                  held_valid;
  logic [INDEX_BITS-1:0] write_index;
  logic [INDEX_BITS-1:0] read_index;
  srsm_pkg::counters_t   counters;

  logic [INDEX_BITS-1:0] write_index_next;
  logic [INDEX_BITS-1:0] read_index_next;
  srsm_pkg::counters_t   counters_next;
  srsm_pkg::rsp_t        rsp_next;
  logic                  issue;

  assign issue     = held_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !held_valid || issue;

  srsm_eval #(
    .INDEX_BITS(INDEX_BITS)
  ) u_eval (
    .req              (held_req),
    .cfg              (cfg),
    .write_index      (write_index),
    .read_index       (read_index),
    .counters         (counters),
    .write_index_next (write_index_next),
    .read_index_next  (read_index_next),
    .counters_next    (counters_next),
    .rsp              (rsp_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slot_count  <= srsm_pkg::SLOT_COUNT_RESET;
      cfg.slot_bytes  <= srsm_pkg::SLOT_BYTES_RESET;
      cfg.region_base <= srsm_pkg::REGION_BASE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        srsm_pkg::CFG_SLOT_COUNT:  cfg.slot_count  <= cfg_wdata[15:0];
        srsm_pkg::CFG_SLOT_BYTES:  cfg.slot_bytes  <= cfg_wdata[15:0];
        srsm_pkg::CFG_REGION_BASE: cfg.region_base <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid  <= 1'b0;
      rsp_valid   <= 1'b0;
      write_index <= '0;
      read_index  <= '0;
      counters    <= '0;
    end else begin
      if (req_valid && req_ready) begin
        held_valid <= 1'b1;
      end else if (issue) begin
        held_valid <= 1'b0;
      end
      if (issue) begin
        rsp_valid   <= 1'b1;
        write_index <= write_index_next;
        read_index  <= read_index_next;
        counters    <= counters_next;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      held_req <= req;
    end
    if (issue) begin
      rsp <= rsp_next;
    end
  end

endmodule

// ===== bench/shared_ring_slot_manager_test.sv =====
// Self-checking bench for shared_ring_slot_manager: directed and random enqueue/dequeue
// beats, checked against an in-bench ring predictor across several register settings.
// Depends on srsm_pkg and the shared_ring_slot_manager RTL.
`timescale 1ns / 1ps

module shared_ring_slot_manager_test;
  import srsm_pkg::*;

  localparam int CLK_PERIOD  = 12;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 12;
  localparam int PHASE_BEATS = 103;
  localparam int HOLD_CYCLES = 150;
  localparam int REPORT_MAX  = 10;

  class ring_ledger;
    logic [15:0] slot_count;
    logic [15:0] slot_bytes;
    logic [63:0] region_base;
    logic [15:0] write_idx;
    logic [15:0] read_idx;
    logic [31:0] enq_total;
    logic [31:0] deq_total;
    rsp_t        owed[$];
    int          mismatches;
    int          beats_seen;
    int          enq_ok;
    int          deq_ok;
    int          again_seen;
    int          error_seen;

    function new();
      slot_count  = SLOT_COUNT_RESET;
      slot_bytes  = SLOT_BYTES_RESET;
      region_base = REGION_BASE_RESET;
      write_idx   = '0;
      read_idx    = '0;
      enq_total   = '0;
      deq_total   = '0;
    endfunction

    function void set_register(logic [CFG_INDEX_BITS-1:0] idx, logic [63:0] value);
      case (idx)
        CFG_SLOT_COUNT:  slot_count  = value[15:0];
        CFG_SLOT_BYTES:  slot_bytes  = value[15:0];
        CFG_REGION_BASE: region_base = value;
        default: ;
      endcase
    endfunction

    // single subtraction of the slot count, 16-bit wrap
    function logic [15:0] step_index(logic [15:0] idx);
      logic [15:0] n;
      n = idx + 16'd1;
      if (n >= slot_count) n = n - slot_count;
      return n;
    endfunction

    function logic [63:0] slot_base_of(logic [15:0] idx);
      return region_base + (64'(idx) + 64'd1) * 64'(slot_bytes);
    endfunction

    function void note_request(req_t beat);
      rsp_t        r;
      logic [15:0] nxt;
      r = '0;
      r.status = ST_OK;
      beats_seen++;
      if (beat.request_length == 16'd0) begin
        r.status = ST_ERROR;
      end else if (beat.action == ACT_ENQUEUE) begin
        nxt = step_index(write_idx);
        if (beat.request_length > slot_bytes) begin
          r.status = ST_ERROR;
        end else if (nxt == read_idx) begin
          r.status = ST_AGAIN;
        end else begin
          r.slot_address    = slot_base_of(write_idx);
          r.transfer_length = beat.request_length;
          write_idx = nxt;
          enq_total = enq_total + 32'd1;
          enq_ok++;
        end
      end else if (read_idx == write_idx) begin
        r.status = ST_AGAIN;
      end else begin
        r.slot_address    = slot_base_of(read_idx);
        r.transfer_length = (beat.request_length < slot_bytes) ? beat.request_length
                                                                 : slot_bytes;
        read_idx  = step_index(read_idx);
        deq_total = deq_total + 32'd1;
        deq_ok++;
      end
      if (r.status == ST_AGAIN) again_seen++;
      if (r.status == ST_ERROR) error_seen++;
      r.enqueued_total = enq_total;
      r.dequeued_total = deq_total;
      owed.push_back(r);
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: result beat with nothing outstanding: %p", $time, got);
        return;
      end
      want = owed.pop_front();
      if (got.status !== want.status || got.slot_address !== want.slot_address ||
          got.transfer_length !== want.transfer_length ||
          got.enqueued_total !== want.enqueued_total ||
          got.dequeued_total !== want.dequeued_total) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("%0t: result beat differs", $time);
          $display("  expected status %0d addr %h len %0d enq %0d deq %0d", want.status,
                   want.slot_address, want.transfer_length, want.enqueued_total,
                   want.dequeued_total);
          $display("  actual   status %0d addr %h len %0d enq %0d deq %0d", got.status,
                   got.slot_address, got.transfer_length, got.enqueued_total,
                   got.dequeued_total);
        end
      end
    endfunction

    function int pending();
      return owed.size();
    endfunction
  endclass

  logic                      clk;
  logic                      rst;
  logic                      req_valid;
  logic                      req_ready;
  req_t                      req;
  logic                      rsp_valid;
  logic                      rsp_ready;
  rsp_t                      rsp;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_wdata;

  ring_ledger ledger = new();
  bit         sender_idles   = 1'b1;
  bit         receiver_idles = 1'b1;
  bit         hold_output    = 1'b0;
  int         cycle_count    = 0;
  int         settings_used  = 0;

  shared_ring_slot_manager DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) ledger.note_request(req);
      if (rsp_valid && rsp_ready) ledger.check_response(rsp);
    end
  end

  // result side: random stall bursts, plus one long hold to back up the pipe
  initial begin
    rsp_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_output) begin
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_output = 1'b0;
        rsp_ready <= 1'b1;
      end else if (receiver_idles && $urandom_range(0, 5) == 0) begin
        rsp_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        rsp_ready <= 1'b1;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  task automatic send_beat(input logic act, input logic [15:0] len);
    if (sender_idles && $urandom_range(0, 5) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= '{action: act, request_length: len};
    do @(posedge clk); while (!req_ready);
  endtask

  // step past the clock edge first so a beat taken at that edge is already in the ledger
  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (ledger.pending() != 0) @(posedge clk);
  endtask

  // upper bits of the 16-bit registers carry junk; only the low 16 bits count
  task automatic write_settings(input logic [15:0] count, input logic [15:0] bytes,
                                input logic [63:0] base);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SLOT_COUNT;
    cfg_wdata <= {junk[63:16], count};
    @(posedge clk);
    ledger.set_register(CFG_SLOT_COUNT, {junk[63:16], count});
    cfg_index <= CFG_SLOT_BYTES;
    cfg_wdata <= {junk[47:0], bytes};
    @(posedge clk);
    ledger.set_register(CFG_SLOT_BYTES, {junk[47:0], bytes});
    cfg_index <= CFG_REGION_BASE;
    cfg_wdata <= base;
    @(posedge clk);
    ledger.set_register(CFG_REGION_BASE, base);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic random_beat(input int enq_pct);
    logic        act;
    logic [15:0] len;
    int          roll;
    act  = ($urandom_range(0, 99) < enq_pct) ? ACT_ENQUEUE : ACT_DEQUEUE;
    roll = $urandom_range(0, 19);
    if (roll == 0) len = 16'd0;
    else if (roll <= 4 || ledger.slot_bytes == 16'd0) len = 16'($urandom);
    else if (roll == 5) len = ledger.slot_bytes;
    else len = 16'($urandom_range(1, ledger.slot_bytes));
    send_beat(act, len);
  endtask

  initial begin
    logic [15:0] count;
    logic [15:0] bytes;
    logic [63:0] base;
    int          enq_pct;
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_SLOT_COUNT;
    cfg_wdata <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset settings: 16 slots of 64 bytes at address 0
    send_beat(ACT_DEQUEUE, 16'd5);
    send_beat(ACT_ENQUEUE, 16'd0);
    send_beat(ACT_DEQUEUE, 16'd0);
    send_beat(ACT_ENQUEUE, 16'd65);
    send_beat(ACT_ENQUEUE, 16'hFFFF);
    send_beat(ACT_ENQUEUE, 16'd64);
    send_beat(ACT_ENQUEUE, 16'd1);
    send_beat(ACT_DEQUEUE, 16'hFFFF);
    send_beat(ACT_DEQUEUE, 16'd1);
    send_beat(ACT_DEQUEUE, 16'd3);
    drain();
    // indices now sit at the new slot count, out of range; address wraps past 2^64
    write_settings(16'd2, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FF00);
    send_beat(ACT_ENQUEUE, 16'hFFFF);
    send_beat(ACT_ENQUEUE, 16'd1);
    send_beat(ACT_DEQUEUE, 16'hFFFF);
    send_beat(ACT_DEQUEUE, 16'd7);
    drain();
    write_settings(16'd1, 16'd1, 64'd0);
    send_beat(ACT_ENQUEUE, 16'd1);
    send_beat(ACT_ENQUEUE, 16'd2);
    send_beat(ACT_DEQUEUE, 16'd1);
    drain();
    // zero slot count: no wrap at all
    write_settings(16'd0, 16'd8, 64'd5);
    send_beat(ACT_ENQUEUE, 16'd8);
    send_beat(ACT_ENQUEUE, 16'd3);
    send_beat(ACT_DEQUEUE, 16'd100);
    drain();
    // zero slot size: enqueues rejected, dequeues move nothing
    write_settings(16'd3, 16'd0, 64'h8000_0000_0000_0000);
    send_beat(ACT_ENQUEUE, 16'd1);
    send_beat(ACT_DEQUEUE, 16'd9);
    send_beat(ACT_DEQUEUE, 16'd9);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: begin count = 16'd3;    bytes = 16'd16;   base = 64'd0; end
        1: begin count = 16'd1;    bytes = 16'hFFFF; base = '1; end
        2: begin count = 16'hFFFF; bytes = 16'd1;    base = 64'd0; end
        3: begin count = 16'd0;    bytes = 16'd200;  base = {$urandom, $urandom}; end
        4: begin count = 16'd2;    bytes = 16'd0;    base = {$urandom, $urandom}; end
        5: begin count = 16'd5;    bytes = 16'hFFFF; base = 64'hFFFF_FFFF_FFFF_FF00; end
        default: begin
          count = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 24));
          bytes = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(1, 256)) : 16'($urandom);
          base  = {$urandom, $urandom};
        end
      endcase
      write_settings(count, bytes, base);
      sender_idles   = (p != 2) && (p < PHASES - 2);
      receiver_idles = (p < PHASES - 2);
      if (p == 2) hold_output = 1'b1;
      enq_pct = 30 + 20 * (p % 3);
      for (int i = 0; i < PHASE_BEATS; i++) random_beat(enq_pct);
    end
    drain();
    repeat (4) @(posedge clk);

    $display("Ran %0d request beats over %0d register settings: %0d enqueues, %0d dequeues,",
             ledger.beats_seen, settings_used + 1, ledger.enq_ok, ledger.deq_ok);
    $display("%0d full/empty retries and %0d rejected requests.",
             ledger.again_seen, ledger.error_seen);
    if (ledger.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
